/* design/privileged_trap_csr_unit_macros.svh */
// assertion macros shared by the privileged trap unit modules
`ifndef PRIVILEGED_TRAP_CSR_UNIT_MACROS_SVH
`define PRIVILEGED_TRAP_CSR_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define PTCU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define PTCU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/ptcu_pkg.sv */
// types, codes and constants of the privileged trap and csr unit
`default_nettype none

package ptcu_pkg;

    // item opcodes
    localparam logic [3:0] OP_IRQ     = 4'd0;
    localparam logic [3:0] OP_CSR     = 4'd1;
    localparam logic [3:0] OP_ECALL   = 4'd2;
    localparam logic [3:0] OP_EBREAK  = 4'd3;
    localparam logic [3:0] OP_ILLEGAL = 4'd4;
    localparam logic [3:0] OP_SRET    = 4'd5;
    localparam logic [3:0] OP_MRET    = 4'd6;
    localparam logic [3:0] OP_WFI     = 4'd7;
    localparam logic [3:0] OP_CMP_LO  = 4'd8;
    localparam logic [3:0] OP_CMP_HI  = 4'd9;
    localparam logic [3:0] OP_EXT     = 4'd10;

    // csr access variants (funct3)
    localparam logic [2:0] VAR_NONE  = 3'd0;
    localparam logic [2:0] VAR_RW    = 3'd1;
    localparam logic [2:0] VAR_RS    = 3'd2;
    localparam logic [2:0] VAR_RC    = 3'd3;
    localparam logic [2:0] VAR_RSVD  = 3'd4;
    localparam logic [2:0] VAR_RWI   = 3'd5;
    localparam logic [2:0] VAR_RSI   = 3'd6;
    localparam logic [2:0] VAR_RCI   = 3'd7;

    // privilege levels
    localparam logic [1:0] PRIV_U = 2'd0;
    localparam logic [1:0] PRIV_S = 2'd1;
    localparam logic [1:0] PRIV_M = 2'd3;

    // csr addresses
    localparam logic [11:0] CSR_M_STATUS  = 12'h300;
    localparam logic [11:0] CSR_M_ISA     = 12'h301;
    localparam logic [11:0] CSR_M_EDELEG  = 12'h302;
    localparam logic [11:0] CSR_M_IDELEG  = 12'h303;
    localparam logic [11:0] CSR_M_IE      = 12'h304;
    localparam logic [11:0] CSR_M_TVEC    = 12'h305;
    localparam logic [11:0] CSR_M_SCRATCH = 12'h340;
    localparam logic [11:0] CSR_M_EPC     = 12'h341;
    localparam logic [11:0] CSR_M_CAUSE   = 12'h342;
    localparam logic [11:0] CSR_M_TVAL    = 12'h343;
    localparam logic [11:0] CSR_M_IP      = 12'h344;
    localparam logic [11:0] CSR_S_STATUS  = 12'h100;
    localparam logic [11:0] CSR_S_IE      = 12'h104;
    localparam logic [11:0] CSR_S_TVEC    = 12'h105;
    localparam logic [11:0] CSR_S_SCRATCH = 12'h140;
    localparam logic [11:0] CSR_S_EPC     = 12'h141;
    localparam logic [11:0] CSR_S_CAUSE   = 12'h142;
    localparam logic [11:0] CSR_S_TVAL    = 12'h143;
    localparam logic [11:0] CSR_S_IP      = 12'h144;
    localparam logic [11:0] CSR_S_ATP     = 12'h180;
    localparam logic [11:0] CSR_MHARTID_K = 12'hF11;
    localparam logic [11:0] CSR_CYCLE     = 12'hC00;
    localparam logic [11:0] CSR_TIME      = 12'hC01;
    localparam logic [11:0] CSR_INSTRET   = 12'hC02;
    localparam logic [11:0] CSR_MCYCLE    = 12'hB00;
    localparam logic [11:0] CSR_MTIME_K   = 12'hB01;
    localparam logic [11:0] CSR_MINSTRET  = 12'hB02;
    localparam logic [11:0] CSR_CYCLEH    = 12'hC80;
    localparam logic [11:0] CSR_TIMEH     = 12'hC81;
    localparam logic [11:0] CSR_INSTRETH  = 12'hC82;
    localparam logic [11:0] CSR_MCYCLEH   = 12'hB80;
    localparam logic [11:0] CSR_MTIMEH_K  = 12'hB81;
    localparam logic [11:0] CSR_MINSTRETH = 12'hB82;

    // read-only constant values
    localparam logic [31:0] MISA_VALUE    = 32'h4040_1101;
    localparam logic [31:0] F11_VALUE     = 32'hFF0F_F0FF;

    // trap register slots
    localparam logic [2:0] T_TVEC    = 3'd0;
    localparam logic [2:0] T_SCRATCH = 3'd1;
    localparam logic [2:0] T_EPC     = 3'd2;
    localparam logic [2:0] T_CAUSE   = 3'd3;
    localparam logic [2:0] T_TVAL    = 3'd4;
    localparam logic [2:0] T_SATP    = 3'd5;
    localparam int         M_REGS    = 5;
    localparam int         S_REGS    = 6;

    // status bit positions
    localparam int ST_SIE  = 1;
    localparam int ST_MIE  = 3;
    localparam int ST_SPIE = 5;
    localparam int ST_MPIE = 7;
    localparam int ST_SPP  = 8;
    localparam int ST_MPP  = 11;

    // pending bit positions
    localparam int IP_SEIP = 9;
    localparam int IP_MTIP = 7;
    localparam int IP_MEIP = 11;

    // exception causes
    localparam logic [31:0] CAUSE_ILLEGAL  = 32'd2;
    localparam logic [31:0] CAUSE_BREAK    = 32'd3;
    localparam logic [31:0] CAUSE_ECALL_U  = 32'd8;
    localparam logic [31:0] CAUSE_ECALL_S  = 32'd9;
    localparam logic [31:0] CAUSE_ECALL_M  = 32'd11;
    localparam logic [31:0] INTR_FLAG      = 32'h8000_0000;

    // interrupt priority, highest first
    localparam int         IRQ_COUNT = 6;
    localparam logic [4:0] IRQ_ORDER [IRQ_COUNT] = '{5'd11, 5'd3, 5'd7, 5'd9, 5'd1, 5'd5};

    // one input item
    typedef struct packed {
        logic [3:0]  opcode;
        logic [31:0] current_pc;
        logic [11:0] csr_number;
        logic [2:0]  csr_variant;
        logic [4:0]  source_index;
        logic [31:0] operand_value;
        logic [1:0]  ext_levels;
        logic [63:0] time_now;
    } t_item;

    // one result item
    typedef struct packed {
        logic        redirect;
        logic [31:0] next_pc;
        logic        trap_taken;
        logic [31:0] read_data;
        logic [1:0]  priv_level;
        logic        waiting;
    } t_result;

endpackage

`default_nettype wire

/* design/ptcu_core.sv */
// architectural state of the trap unit and its single-pass update
`default_nettype none
`include "privileged_trap_csr_unit_macros.svh"

module ptcu_core import ptcu_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_fire,
    input  wire t_item   i_item,
    output t_result      o_result
);

    logic [31:0] r_status, n_status;
    logic [31:0] r_ie, n_ie;
    logic [31:0] r_ip, n_ip;
    logic [31:0] r_medeleg, n_medeleg;
    logic [31:0] r_mideleg, n_mideleg;
    logic [31:0] r_mtrap [M_REGS];
    logic [31:0] n_mtrap [M_REGS];
    logic [31:0] r_strap [S_REGS];
    logic [31:0] n_strap [S_REGS];
    logic [1:0]  r_priv, n_priv;
    logic        r_wfi, n_wfi;
    logic [63:0] r_tcmp, n_tcmp;

    // timer check and interrupt selection
    logic [31:0] ip_chk;
    logic [31:0] pend;
    logic        irq_found;
    logic [4:0]  irq_sel;

    always_comb begin
        ip_chk         = r_ip;
        ip_chk[IP_MTIP] = (i_item.time_now >= r_tcmp);
        pend           = ip_chk & r_ie;
        irq_found      = 1'b0;
        irq_sel        = 5'd0;
        for (int i = 0; i < IRQ_COUNT; i++) begin
            if (!irq_found && pend[IRQ_ORDER[i]]) begin
                if (r_mideleg[IRQ_ORDER[i]]) begin
                    if (r_priv == PRIV_U || (r_priv == PRIV_S && r_status[ST_SIE])) begin
                        irq_found = 1'b1;
                        irq_sel   = IRQ_ORDER[i];
                    end
                end else if (r_priv != PRIV_M || r_status[ST_MIE]) begin
                    irq_found = 1'b1;
                    irq_sel   = IRQ_ORDER[i];
                end
            end
        end
    end

    // csr read mux
    logic [31:0] csr_old;

    always_comb begin
        case (i_item.csr_number)
            CSR_M_STATUS, CSR_S_STATUS: csr_old = r_status;
            CSR_M_EDELEG:             csr_old = r_medeleg;
            CSR_M_IDELEG:             csr_old = r_mideleg;
            CSR_M_IE, CSR_S_IE:       csr_old = r_ie;
            CSR_M_IP, CSR_S_IP:       csr_old = r_ip;
            CSR_M_TVEC:               csr_old = r_mtrap[T_TVEC];
            CSR_M_SCRATCH:            csr_old = r_mtrap[T_SCRATCH];
            CSR_M_EPC:                csr_old = r_mtrap[T_EPC];
            CSR_M_CAUSE:              csr_old = r_mtrap[T_CAUSE];
            CSR_M_TVAL:               csr_old = r_mtrap[T_TVAL];
            CSR_S_TVEC:               csr_old = r_strap[T_TVEC];
            CSR_S_SCRATCH:            csr_old = r_strap[T_SCRATCH];
            CSR_S_EPC:                csr_old = r_strap[T_EPC];
            CSR_S_CAUSE:              csr_old = r_strap[T_CAUSE];
            CSR_S_TVAL:               csr_old = r_strap[T_TVAL];
            CSR_S_ATP:                csr_old = r_strap[T_SATP];
            CSR_M_ISA:                csr_old = MISA_VALUE;
            CSR_MHARTID_K:            csr_old = F11_VALUE;
            CSR_CYCLE, CSR_TIME, CSR_INSTRET,
            CSR_MCYCLE, CSR_MTIME_K, CSR_MINSTRET:
                                      csr_old = i_item.time_now[31:0];
            CSR_CYCLEH, CSR_TIMEH, CSR_INSTRETH,
            CSR_MCYCLEH, CSR_MTIMEH_K, CSR_MINSTRETH:
                                      csr_old = i_item.time_now[63:32];
            default:                  csr_old = '0;
        endcase
    end

    // csr new value and write condition
    logic [31:0] csr_new;
    logic [31:0] imm;
    logic        csr_we;

    always_comb begin
        imm = {27'd0, i_item.source_index};
        case (i_item.csr_variant)
            VAR_RW:  csr_new = i_item.operand_value;
            VAR_RS:  csr_new = csr_old | i_item.operand_value;
            VAR_RC:  csr_new = csr_old & ~i_item.operand_value;
            VAR_RWI: csr_new = imm;
            VAR_RSI: csr_new = csr_old | imm;
            VAR_RCI: csr_new = csr_old & ~imm;
            default: csr_new = csr_old;
        endcase
        csr_we = (i_item.csr_variant == VAR_RW) || (i_item.csr_variant == VAR_RWI) ||
                 ((i_item.source_index != 5'd0) && (i_item.csr_variant != VAR_NONE) &&
                  (i_item.csr_variant != VAR_RSVD));
    end

    // main next-state pass
    logic        held;
    logic        trap_req;
    logic [31:0] trap_cause;
    logic [31:0] trap_tval;
    logic        trap_intr;
    logic [4:0]  trap_idx;
    logic [31:0] trap_deleg;
    logic        trap_to_s;
    logic [31:0] trap_vec;

    always_comb begin
        n_status  = r_status;
        n_ie      = r_ie;
        n_ip      = r_ip;
        n_medeleg = r_medeleg;
        n_mideleg = r_mideleg;
        n_mtrap   = r_mtrap;
        n_strap   = r_strap;
        n_priv    = r_priv;
        n_wfi     = r_wfi;
        n_tcmp    = r_tcmp;
        o_result  = '0;
        trap_req  = 1'b0;
        trap_cause = '0;
        trap_tval  = '0;
        held = r_wfi && (i_item.opcode >= OP_CSR) && (i_item.opcode <= OP_WFI);

        case (i_item.opcode)
            OP_IRQ: begin
                n_ip = ip_chk;
                if (irq_found) begin
                    trap_req   = 1'b1;
                    trap_cause = INTR_FLAG | {27'd0, irq_sel};
                end
            end
            OP_CSR: begin
                if (!held) begin
                    o_result.read_data = csr_old;
                    if (csr_we) begin
                        case (i_item.csr_number)
                            CSR_M_STATUS, CSR_S_STATUS: n_status = csr_new;
                            CSR_M_EDELEG:  n_medeleg          = csr_new;
                            CSR_M_IDELEG:  n_mideleg          = csr_new;
                            CSR_M_IE, CSR_S_IE: n_ie          = csr_new;
                            CSR_M_IP, CSR_S_IP: n_ip          = csr_new;
                            CSR_M_TVEC:    n_mtrap[T_TVEC]    = csr_new;
                            CSR_M_SCRATCH: n_mtrap[T_SCRATCH] = csr_new;
                            CSR_M_EPC:     n_mtrap[T_EPC]     = csr_new;
                            CSR_M_CAUSE:   n_mtrap[T_CAUSE]   = csr_new;
                            CSR_M_TVAL:    n_mtrap[T_TVAL]    = csr_new;
                            CSR_S_TVEC:    n_strap[T_TVEC]    = csr_new;
                            CSR_S_SCRATCH: n_strap[T_SCRATCH] = csr_new;
                            CSR_S_EPC:     n_strap[T_EPC]     = csr_new;
                            CSR_S_CAUSE:   n_strap[T_CAUSE]   = csr_new;
                            CSR_S_TVAL:    n_strap[T_TVAL]    = csr_new;
                            CSR_S_ATP:     n_strap[T_SATP]    = csr_new;
                            default: ;
                        endcase
                    end
                end
            end
            OP_ECALL: begin
                if (!held) begin
                    trap_req = 1'b1;
                    if (r_priv == PRIV_M)      trap_cause = CAUSE_ECALL_M;
                    else if (r_priv == PRIV_S) trap_cause = CAUSE_ECALL_S;
                    else                       trap_cause = CAUSE_ECALL_U;
                end
            end
            OP_EBREAK: begin
                if (!held) begin
                    trap_req   = 1'b1;
                    trap_cause = CAUSE_BREAK;
                    trap_tval  = i_item.current_pc;
                end
            end
            OP_ILLEGAL: begin
                if (!held) begin
                    trap_req   = 1'b1;
                    trap_cause = CAUSE_ILLEGAL;
                    trap_tval  = i_item.operand_value;
                end
            end
            OP_SRET: begin
                if (!held) begin
                    n_status[ST_SIE]  = r_status[ST_SPIE];
                    n_status[ST_SPIE] = 1'b1;
                    n_status[ST_SPP]  = 1'b0;
                    n_priv            = {1'b0, r_status[ST_SPP]};
                    o_result.redirect = 1'b1;
                    o_result.next_pc  = r_strap[T_EPC];
                end
            end
            OP_MRET: begin
                if (!held) begin
                    n_status[ST_MIE]            = r_status[ST_MPIE];
                    n_status[ST_MPIE]           = 1'b1;
                    n_status[ST_MPP+1:ST_MPP]   = 2'b00;
                    n_priv                      = r_status[ST_MPP+1:ST_MPP];
                    o_result.redirect           = 1'b1;
                    o_result.next_pc            = r_mtrap[T_EPC];
                end
            end
            OP_WFI: begin
                if (!held) begin
                    n_status[ST_MIE] = 1'b1;
                    n_wfi            = 1'b1;
                end
            end
            OP_CMP_LO: n_tcmp[31:0]  = i_item.operand_value;
            OP_CMP_HI: n_tcmp[63:32] = i_item.operand_value;
            OP_EXT: begin
                n_ip[IP_MEIP] = i_item.ext_levels[0];
                n_ip[IP_SEIP] = i_item.ext_levels[1];
            end
            default: ;
        endcase

        // trap entry, delegated to s mode or taken in m mode
        trap_intr  = trap_cause[31];
        trap_idx   = trap_cause[4:0];
        trap_deleg = trap_intr ? r_mideleg : r_medeleg;
        trap_to_s  = (r_priv != PRIV_M) && trap_deleg[trap_idx];
        trap_vec   = trap_to_s ? r_strap[T_TVEC] : r_mtrap[T_TVEC];
        if (trap_req) begin
            n_wfi = 1'b0;
            if (trap_to_s) begin
                n_strap[T_EPC]    = i_item.current_pc;
                n_strap[T_CAUSE]  = trap_cause;
                n_strap[T_TVAL]   = trap_tval;
                n_status[ST_SIE]  = 1'b0;
                n_status[ST_SPIE] = r_status[ST_SIE];
                n_status[ST_SPP]  = r_priv[0];
                n_priv            = PRIV_S;
            end else begin
                n_mtrap[T_EPC]            = i_item.current_pc;
                n_mtrap[T_CAUSE]          = trap_cause;
                n_mtrap[T_TVAL]           = trap_tval;
                n_status[ST_MIE]          = 1'b0;
                n_status[ST_MPIE]         = r_status[ST_MIE];
                n_status[ST_MPP+1:ST_MPP] = r_priv;
                n_priv                    = PRIV_M;
            end
            o_result.redirect   = 1'b1;
            o_result.trap_taken = 1'b1;
            if (trap_intr && trap_vec[0]) begin
                o_result.next_pc = {trap_vec[31:2], 2'b00} + {25'd0, trap_idx, 2'b00};
            end else begin
                o_result.next_pc = {trap_vec[31:2], 2'b00};
            end
        end

        o_result.priv_level = n_priv;
        o_result.waiting    = n_wfi;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status  <= '0;
            r_ie      <= '0;
            r_ip      <= '0;
            r_medeleg <= '0;
            r_mideleg <= '0;
            r_mtrap   <= '{default: '0};
            r_strap   <= '{default: '0};
            r_priv    <= PRIV_M;
            r_wfi     <= 1'b0;
            r_tcmp    <= '1;
        end else if (i_fire) begin
            r_status  <= n_status;
            r_ie      <= n_ie;
            r_ip      <= n_ip;
            r_medeleg <= n_medeleg;
            r_mideleg <= n_mideleg;
            r_mtrap   <= n_mtrap;
            r_strap   <= n_strap;
            r_priv    <= n_priv;
            r_wfi     <= n_wfi;
            r_tcmp    <= n_tcmp;
        end
    end

    // a trap always clears the wait flag and lands in s or m mode
    `PTCU_ASSERT_NEXT(a_trap_clears_wfi, i_clk, i_rst_n, i_fire && trap_req, !r_wfi, "trap left wfi set")
    `PTCU_ASSERT_NEXT(a_trap_priv, i_clk, i_rst_n, i_fire && trap_req, (r_priv == PRIV_S) || (r_priv == PRIV_M), "trap entered a bad privilege")

endmodule

`default_nettype wire

/* design/privileged_trap_csr_unit.sv */
// top level of the privileged trap and csr unit: input and result registers around the core
`default_nettype none
`include "privileged_trap_csr_unit_macros.svh"

// Each accepted item is captured in an input register, its full effect on the trap CSRs,
// privilege and WFI state is worked out by the core, and exactly one result item lands in
// the output register once that register is empty or being taken. While results are taken,
// the block sustains one item per cycle, set by the single state update pass in the core,
// which the following item sees. While a result waits to be taken, one more item is still
// accepted into the input register.

module privileged_trap_csr_unit import ptcu_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [3:0]  i_opcode,
    input  wire logic [31:0] i_current_pc,
    input  wire logic [11:0] i_csr_number,
    input  wire logic [2:0]  i_csr_variant,
    input  wire logic [4:0]  i_source_index,
    input  wire logic [31:0] i_operand_value,
    input  wire logic [1:0]  i_ext_levels,
    input  wire logic [63:0] i_time_now,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_redirect,
    output logic [31:0]      o_next_pc,
    output logic             o_trap_taken,
    output logic [31:0]      o_read_data,
    output logic [1:0]       o_priv_level,
    output logic             o_waiting
);

    t_item   r_item;
    logic    r_in_vld;
    t_result r_res;
    logic    r_out_vld;
    t_result core_res;
    logic    advance;

    // item moves from the input register into the result register
    assign advance    = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item.opcode        <= i_opcode;
            r_item.current_pc    <= i_current_pc;
            r_item.csr_number    <= i_csr_number;
            r_item.csr_variant   <= i_csr_variant;
            r_item.source_index  <= i_source_index;
            r_item.operand_value <= i_operand_value;
            r_item.ext_levels    <= i_ext_levels;
            r_item.time_now      <= i_time_now;
        end
    end

    ptcu_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_item),
        .o_result (core_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= core_res;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_redirect   = r_res.redirect;
    assign o_next_pc    = r_res.next_pc;
    assign o_trap_taken = r_res.trap_taken;
    assign o_read_data  = r_res.read_data;
    assign o_priv_level = r_res.priv_level;
    assign o_waiting    = r_res.waiting;

    // pending item holds while the result side is stalled
    `PTCU_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, r_in_vld && r_out_vld && !i_out_ready, r_in_vld, "input item dropped under stall")
    // input side only backs up when both registers are full
    `PTCU_ASSERT_NOW(a_ready_low, i_clk, i_rst_n, !o_in_ready, r_in_vld && r_out_vld && !i_out_ready, "input stalled without cause")
    // a trap result always redirects
    `PTCU_ASSERT_NOW(a_trap_redirect, i_clk, i_rst_n, r_out_vld && r_res.trap_taken, r_res.redirect, "trap without redirect")

endmodule

`default_nettype wire

/* tb/privileged_trap_csr_unit_checker.sv */
// checker for the privileged trap unit: watches both channels, predicts each result and compares
`timescale 1ns / 1ps

module privileged_trap_csr_unit_checker import ptcu_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_in_ready,
    input  wire t_item   i_item,
    input  wire logic    i_out_valid,
    input  wire logic    i_out_ready,
    input  wire t_result i_result,
    output int           o_fail_count,
    output int           o_pending
);

    // status bits saved and restored on supervisor and machine trap entry
    localparam logic [31:0] S_TRAP_BITS = (32'd1 << ST_SIE) | (32'd1 << ST_SPIE) |
                                          (32'd1 << ST_SPP);
    localparam logic [31:0] M_TRAP_BITS = (32'd1 << ST_MIE) | (32'd1 << ST_MPIE) |
                                          (32'd3 << ST_MPP);

    // architectural state as the unit should hold it
    logic [31:0] mstatus_q;
    logic [31:0] ie_q;
    logic [31:0] ip_q;
    logic [31:0] edeleg_q;
    logic [31:0] ideleg_q;
    logic [31:0] m_csr [M_REGS];
    logic [31:0] s_csr [S_REGS];
    logic [1:0]  priv_q;
    logic        wfi_q;
    logic [63:0] mtimecmp_q;

    t_result expected_results [$];
    int      mismatches  = 0;
    int      outstanding = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = outstanding;

    // one line per mismatch
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ptcu check: %s got %h expected %h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic check_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    // trap entry into supervisor or machine mode, returns the handler address
    task automatic take_trap(input logic [31:0] cause, input logic [31:0] tval,
                             input logic [31:0] pc, output logic [31:0] target);
        logic [4:0]  code;
        logic        to_s;
        logic [31:0] tvec;
        code = cause[4:0];
        to_s = (priv_q != PRIV_M) && (cause[31] ? ideleg_q[code] : edeleg_q[code]);
        wfi_q = 1'b0;
        if (to_s) begin
            s_csr[T_EPC]   = pc;
            s_csr[T_CAUSE] = cause;
            s_csr[T_TVAL]  = tval;
            mstatus_q = (mstatus_q & ~S_TRAP_BITS) | ({31'd0, priv_q[0]} << ST_SPP) |
                        ({31'd0, mstatus_q[ST_SIE]} << ST_SPIE);
            priv_q = PRIV_S;
            tvec   = s_csr[T_TVEC];
        end else begin
            m_csr[T_EPC]   = pc;
            m_csr[T_CAUSE] = cause;
            m_csr[T_TVAL]  = tval;
            mstatus_q = (mstatus_q & ~M_TRAP_BITS) | ({30'd0, priv_q} << ST_MPP) |
                        ({31'd0, mstatus_q[ST_MIE]} << ST_MPIE);
            priv_q = PRIV_M;
            tvec   = m_csr[T_TVEC];
        end
        // vectored entry applies to interrupts only
        if (cause[31] && tvec[0]) target = {tvec[31:2], 2'b00} + {25'd0, code, 2'b00};
        else target = {tvec[31:2], 2'b00};
    endtask

    // effect of one item on the state, and the result it should produce
    task automatic predict_event(input t_item it, output t_result r);
        logic [31:0] old_v;
        logic [31:0] new_v;
        logic [31:0] pend;
        logic [31:0] target;
        logic [31:0] cause;
        logic [31:0] tval;
        logic [31:0] imm;
        logic [4:0]  num;
        logic        held;
        logic        fire;
        logic        done;
        logic        wr;
        r    = '0;
        imm  = {27'd0, it.source_index};
        held = wfi_q && (it.opcode >= OP_CSR) && (it.opcode <= OP_WFI);
        if (it.opcode == OP_IRQ) begin
            // timer level first, then the highest priority interrupt allowed to fire
            ip_q[IP_MTIP] = (it.time_now >= mtimecmp_q);
            pend = ip_q & ie_q;
            done = 1'b0;
            for (int i = 0; i < IRQ_COUNT; i++) begin
                num = IRQ_ORDER[i];
                if (!done && pend[num]) begin
                    if (ideleg_q[num])
                        fire = (priv_q == PRIV_U) || (priv_q == PRIV_S && mstatus_q[ST_SIE]);
                    else
                        fire = (priv_q != PRIV_M) || mstatus_q[ST_MIE];
                    if (fire) begin
                        take_trap(INTR_FLAG | {27'd0, num}, 32'd0, it.current_pc, target);
                        r.redirect   = 1'b1;
                        r.next_pc    = target;
                        r.trap_taken = 1'b1;
                        done         = 1'b1;
                    end
                end
            end
        end else if (held) begin
            // held by wfi: nothing changes
        end else if (it.opcode == OP_CSR) begin
            case (it.csr_number)
                CSR_M_STATUS, CSR_S_STATUS: old_v = mstatus_q;
                CSR_M_EDELEG:             old_v = edeleg_q;
                CSR_M_IDELEG:             old_v = ideleg_q;
                CSR_M_IE, CSR_S_IE:       old_v = ie_q;
                CSR_M_IP, CSR_S_IP:       old_v = ip_q;
                CSR_M_TVEC:               old_v = m_csr[T_TVEC];
                CSR_M_SCRATCH:            old_v = m_csr[T_SCRATCH];
                CSR_M_EPC:                old_v = m_csr[T_EPC];
                CSR_M_CAUSE:              old_v = m_csr[T_CAUSE];
                CSR_M_TVAL:               old_v = m_csr[T_TVAL];
                CSR_S_TVEC:               old_v = s_csr[T_TVEC];
                CSR_S_SCRATCH:            old_v = s_csr[T_SCRATCH];
                CSR_S_EPC:                old_v = s_csr[T_EPC];
                CSR_S_CAUSE:              old_v = s_csr[T_CAUSE];
                CSR_S_TVAL:               old_v = s_csr[T_TVAL];
                CSR_S_ATP:                old_v = s_csr[T_SATP];
                CSR_M_ISA:                old_v = MISA_VALUE;
                CSR_MHARTID_K:            old_v = F11_VALUE;
                CSR_CYCLE, CSR_TIME, CSR_INSTRET, CSR_MCYCLE, CSR_MTIME_K, CSR_MINSTRET:
                    old_v = it.time_now[31:0];
                CSR_CYCLEH, CSR_TIMEH, CSR_INSTRETH, CSR_MCYCLEH, CSR_MTIMEH_K, CSR_MINSTRETH:
                    old_v = it.time_now[63:32];
                default:                  old_v = 32'd0;
            endcase
            case (it.csr_variant)
                VAR_RW:  new_v = it.operand_value;
                VAR_RS:  new_v = old_v | it.operand_value;
                VAR_RC:  new_v = old_v & ~it.operand_value;
                VAR_RWI: new_v = imm;
                VAR_RSI: new_v = old_v | imm;
                VAR_RCI: new_v = old_v & ~imm;
                default: new_v = old_v;
            endcase
            // set and clear forms with a zero source leave the register alone
            wr = (it.csr_variant == VAR_RW) || (it.csr_variant == VAR_RWI) ||
                 (it.source_index != 5'd0 && it.csr_variant != VAR_NONE &&
                  it.csr_variant != VAR_RSVD);
            if (wr) begin
                case (it.csr_number)
                    CSR_M_STATUS, CSR_S_STATUS: mstatus_q      = new_v;
                    CSR_M_EDELEG:             edeleg_q         = new_v;
                    CSR_M_IDELEG:             ideleg_q         = new_v;
                    CSR_M_IE, CSR_S_IE:       ie_q             = new_v;
                    CSR_M_IP, CSR_S_IP:       ip_q             = new_v;
                    CSR_M_TVEC:               m_csr[T_TVEC]    = new_v;
                    CSR_M_SCRATCH:            m_csr[T_SCRATCH] = new_v;
                    CSR_M_EPC:                m_csr[T_EPC]     = new_v;
                    CSR_M_CAUSE:              m_csr[T_CAUSE]   = new_v;
                    CSR_M_TVAL:               m_csr[T_TVAL]    = new_v;
                    CSR_S_TVEC:               s_csr[T_TVEC]    = new_v;
                    CSR_S_SCRATCH:            s_csr[T_SCRATCH] = new_v;
                    CSR_S_EPC:                s_csr[T_EPC]     = new_v;
                    CSR_S_CAUSE:              s_csr[T_CAUSE]   = new_v;
                    CSR_S_TVAL:               s_csr[T_TVAL]    = new_v;
                    CSR_S_ATP:                s_csr[T_SATP]    = new_v;
                    default: ;
                endcase
            end
            r.read_data = old_v;
        end else if (it.opcode == OP_ECALL || it.opcode == OP_EBREAK ||
                     it.opcode == OP_ILLEGAL) begin
            // synchronous exceptions
            tval = 32'd0;
            if (it.opcode == OP_ECALL) begin
                case (priv_q)
                    PRIV_M:  cause = CAUSE_ECALL_M;
                    PRIV_S:  cause = CAUSE_ECALL_S;
                    default: cause = CAUSE_ECALL_U;
                endcase
            end else if (it.opcode == OP_EBREAK) begin
                cause = CAUSE_BREAK;
                tval  = it.current_pc;
            end else begin
                cause = CAUSE_ILLEGAL;
                tval  = it.operand_value;
            end
            take_trap(cause, tval, it.current_pc, target);
            r.redirect   = 1'b1;
            r.next_pc    = target;
            r.trap_taken = 1'b1;
        end else if (it.opcode == OP_SRET) begin
            priv_q    = {1'b0, mstatus_q[ST_SPP]};
            mstatus_q = (mstatus_q & ~S_TRAP_BITS) | (32'd1 << ST_SPIE) |
                        ({31'd0, mstatus_q[ST_SPIE]} << ST_SIE);
            r.redirect = 1'b1;
            r.next_pc  = s_csr[T_EPC];
        end else if (it.opcode == OP_MRET) begin
            priv_q    = mstatus_q[ST_MPP +: 2];
            mstatus_q = (mstatus_q & ~M_TRAP_BITS) | (32'd1 << ST_MPIE) |
                        ({31'd0, mstatus_q[ST_MPIE]} << ST_MIE);
            r.redirect = 1'b1;
            r.next_pc  = m_csr[T_EPC];
        end else if (it.opcode == OP_WFI) begin
            // wfi also enables machine interrupts
            mstatus_q[ST_MIE] = 1'b1;
            wfi_q = 1'b1;
        end else if (it.opcode == OP_CMP_LO) begin
            mtimecmp_q[31:0] = it.operand_value;
        end else if (it.opcode == OP_CMP_HI) begin
            mtimecmp_q[63:32] = it.operand_value;
        end else if (it.opcode == OP_EXT) begin
            ip_q[IP_MEIP] = it.ext_levels[0];
            ip_q[IP_SEIP] = it.ext_levels[1];
        end
        r.priv_level = priv_q;
        r.waiting    = wfi_q;
    endtask

    // predict on every accepted item, compare on every accepted result
    always @(posedge i_clk) begin : track
        t_result want_r;
        if (!i_rst_n) begin
            mstatus_q  = '0;
            ie_q       = '0;
            ip_q       = '0;
            edeleg_q   = '0;
            ideleg_q   = '0;
            for (int i = 0; i < M_REGS; i++) m_csr[i] = '0;
            for (int i = 0; i < S_REGS; i++) s_csr[i] = '0;
            priv_q     = PRIV_M;
            wfi_q      = 1'b0;
            mtimecmp_q = '1;
            expected_results.delete();
            outstanding <= 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                predict_event(i_item, want_r);
                expected_results.push_back(want_r);
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing expected",
                                    {32'd0, i_result.next_pc}, 64'd0);
                end else begin
                    want_r = expected_results.pop_front();
                    check_field("redirect", 64'(i_result.redirect), 64'(want_r.redirect));
                    check_field("next_pc", 64'(i_result.next_pc), 64'(want_r.next_pc));
                    check_field("trap_taken", 64'(i_result.trap_taken),
                                64'(want_r.trap_taken));
                    check_field("read_data", 64'(i_result.read_data), 64'(want_r.read_data));
                    check_field("priv_level", 64'(i_result.priv_level),
                                64'(want_r.priv_level));
                    check_field("waiting", 64'(i_result.waiting), 64'(want_r.waiting));
                end
            end
            outstanding <= expected_results.size();
        end
    end

endmodule

/* tb/privileged_trap_csr_unit_test.sv */
// testbench top for the privileged trap unit: clock, reset, item stimulus and verdict
`timescale 1ns / 1ps

module privileged_trap_csr_unit_test import ptcu_pkg::*; ();

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    t_item       ev        = '0;
    logic        out_ready = 1'b0;
    wire logic   in_ready;
    wire logic   out_valid;
    wire logic   redirect;
    wire logic [31:0] next_pc;
    wire logic   trap_taken;
    wire logic [31:0] read_data;
    wire logic [1:0]  priv_level;
    wire logic   waiting;
    t_result     result_bus;
    int          fail_count;
    int          pending;
    bit          idle_on   = 1'b1;
    int          sent      = 0;
    logic [63:0] cmp_hint  = '1;

    assign result_bus = {redirect, next_pc, trap_taken, read_data, priv_level, waiting};

    privileged_trap_csr_unit uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_opcode        (ev.opcode),
        .i_current_pc    (ev.current_pc),
        .i_csr_number    (ev.csr_number),
        .i_csr_variant   (ev.csr_variant),
        .i_source_index  (ev.source_index),
        .i_operand_value (ev.operand_value),
        .i_ext_levels    (ev.ext_levels),
        .i_time_now      (ev.time_now),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_redirect      (redirect),
        .o_next_pc       (next_pc),
        .o_trap_taken    (trap_taken),
        .o_read_data     (read_data),
        .o_priv_level    (priv_level),
        .o_waiting       (waiting)
    );

    privileged_trap_csr_unit_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_item       (ev),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_result     (result_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #4 clk = ~clk;

    // result side stalls at random while idling is enabled
    always @(posedge clk) begin
        out_ready <= (idle_on && $urandom_range(0, 99) < 24) ? 1'b0 : 1'b1;
    end

    // hard limit on the run
    initial begin
        #2_000_000;
        $display("[privileged_trap_csr_unit] ERROR");
        $finish;
    end

    // mostly the csrs the unit implements, sometimes any address
    function automatic logic [11:0] pick_csr();
        case ($urandom_range(0, 38))
            0:  return CSR_M_STATUS;   1:  return CSR_S_STATUS;  2:  return CSR_M_ISA;
            3:  return CSR_M_EDELEG;   4:  return CSR_M_IDELEG;  5:  return CSR_M_IE;
            6:  return CSR_S_IE;       7:  return CSR_M_TVEC;    8:  return CSR_M_SCRATCH;
            9:  return CSR_M_EPC;      10: return CSR_M_CAUSE;   11: return CSR_M_TVAL;
            12: return CSR_M_IP;       13: return CSR_S_TVEC;    14: return CSR_S_SCRATCH;
            15: return CSR_S_EPC;      16: return CSR_S_CAUSE;   17: return CSR_S_TVAL;
            18: return CSR_S_IP;       19: return CSR_S_ATP;     20: return CSR_MHARTID_K;
            21: return CSR_CYCLE;      22: return CSR_TIME;      23: return CSR_INSTRET;
            24: return CSR_MCYCLE;     25: return CSR_MTIME_K;   26: return CSR_MINSTRET;
            27: return CSR_CYCLEH;     28: return CSR_TIMEH;     29: return CSR_INSTRETH;
            30: return CSR_MCYCLEH;    31: return CSR_MTIMEH_K;  32: return CSR_MINSTRETH;
            default: return 12'($urandom);
        endcase
    endfunction

    // item of the given kind with random content; time tends to sit near the compare value
    function automatic t_item fill_event(input logic [3:0] op);
        t_item       it;
        logic [63:0] delta;
        it.opcode        = op;
        it.current_pc    = $urandom;
        it.csr_number    = pick_csr();
        it.csr_variant   = 3'($urandom_range(0, 7));
        it.source_index  = ($urandom_range(0, 4) == 0) ? 5'd0 : 5'($urandom_range(0, 31));
        it.operand_value = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF : $urandom;
        it.ext_levels    = 2'($urandom_range(0, 3));
        delta            = 64'($urandom_range(0, 4));
        case ($urandom_range(0, 2))
            0, 1:    it.time_now = cmp_hint - 64'd2 + delta;
            default: it.time_now = {$urandom, $urandom};
        endcase
        return it;
    endfunction

    function automatic t_item csr_event(input logic [11:0] num, input logic [2:0] variant,
                                        input logic [4:0] imm, input logic [31:0] val);
        t_item it;
        it               = fill_event(OP_CSR);
        it.csr_number    = num;
        it.csr_variant   = variant;
        it.source_index  = imm;
        it.operand_value = val;
        return it;
    endfunction

    // present one item after a random gap and hold it until accepted
    task automatic send_event(input t_item it);
        int gap;
        gap = 0;
        if (idle_on) while ($urandom_range(0, 99) < 24) gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        ev       <= it;
        do @(posedge clk); while (!in_ready);
        if (it.opcode == OP_CMP_LO) cmp_hint[31:0] = it.operand_value;
        if (it.opcode == OP_CMP_HI) cmp_hint[63:32] = it.operand_value;
        sent++;
    endtask

    initial begin
        t_item it;
        int    kind;
        int    n;
        logic [3:0] op;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // read-only and counter csrs, unknown address, no-write variants
        send_event(csr_event(CSR_M_ISA, VAR_RW, 5'd3, 32'hFFFF_FFFF));
        it = csr_event(CSR_TIME, VAR_RSVD, 5'd7, 32'h0);
        it.time_now = '1;
        send_event(it);
        send_event(csr_event(12'h7C0, VAR_RW, 5'd31, 32'hFFFF_FFFF));
        send_event(csr_event(CSR_M_TVEC, VAR_RW, 5'd1, 32'h0000_1001));
        send_event(csr_event(CSR_S_TVEC, VAR_RW, 5'd1, 32'h0000_2001));
        send_event(csr_event(CSR_M_IE, VAR_RW, 5'd1, 32'hFFFF_FFFF));
        // set with a zero source must not write
        send_event(csr_event(CSR_M_STATUS, VAR_RS, 5'd0, 32'hFFFF_FFFF));
        send_event(csr_event(CSR_M_EDELEG, VAR_RW, 5'd1, 32'd1 << CAUSE_ECALL_U));

        // exceptions from machine mode
        it = fill_event(OP_ECALL);
        it.current_pc = '1;
        send_event(it);
        it = fill_event(OP_EBREAK);
        it.current_pc = '0;
        send_event(it);
        it = fill_event(OP_ILLEGAL);
        it.operand_value = '1;
        send_event(it);

        // drop to user, delegated ecall, ecall from supervisor
        send_event(csr_event(CSR_M_STATUS, VAR_RW, 5'd1, 32'h0));
        send_event(fill_event(OP_MRET));
        send_event(fill_event(OP_ECALL));
        send_event(fill_event(OP_ECALL));

        // mret into level two, its ecall, then sret
        send_event(csr_event(CSR_M_STATUS, VAR_RW, 5'd1, 32'd2 << ST_MPP));
        send_event(fill_event(OP_MRET));
        send_event(fill_event(OP_ECALL));
        send_event(fill_event(OP_SRET));

        // timer interrupt with compare at zero, vectored
        it = fill_event(OP_CMP_LO);
        it.operand_value = '0;
        send_event(it);
        it = fill_event(OP_CMP_HI);
        it.operand_value = '0;
        send_event(it);
        it = fill_event(OP_IRQ);
        it.time_now = '0;
        send_event(it);

        // wfi holds a csr access until an external interrupt is taken
        send_event(fill_event(OP_WFI));
        send_event(csr_event(CSR_M_SCRATCH, VAR_RW, 5'd1, 32'hA5A5_A5A5));
        it = fill_event(OP_EXT);
        it.ext_levels = 2'b11;
        send_event(it);
        send_event(fill_event(OP_IRQ));

        // unused opcode
        send_event(fill_event(4'hF));

        // random sequences; the middle stretch runs without any idling
        while (sent < 630) begin
            idle_on <= !(sent >= 280 && sent < 430);
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
                // single noise item
                if ($urandom_range(0, 99) < 3) begin
                    op = 4'($urandom_range(11, 15));
                end else begin
                    op = 4'($urandom_range(0, 9));
                    if (op >= OP_WFI) op = op + 4'd1;
                end
                send_event(fill_event(op));
            end else if (kind < 60) begin
                // privilege round trip through mret or sret and a trap
                send_event(csr_event(CSR_M_STATUS, VAR_RW, 5'd1, $urandom));
                if ($urandom_range(0, 1))
                    send_event(csr_event(CSR_M_EDELEG, VAR_RW, 5'd1,
                        ($urandom_range(0, 3) == 0) ? $urandom : ($urandom & 32'h0000_0B0C)));
                send_event(fill_event($urandom_range(0, 1) ? OP_MRET : OP_SRET));
                send_event(fill_event(4'(OP_ECALL + $urandom_range(0, 2))));
                repeat ($urandom_range(0, 2)) send_event(fill_event(OP_CSR));
                send_event(fill_event($urandom_range(0, 1) ? OP_MRET : OP_SRET));
            end else if (kind < 85) begin
                // interrupt setup followed by checks near the compare value
                send_event(csr_event(CSR_M_IE, VAR_RW, 5'd1, $urandom & 32'h0000_0AAA));
                send_event(csr_event(CSR_M_IDELEG, VAR_RW, 5'd1, $urandom & 32'h0000_0AAA));
                send_event(csr_event($urandom_range(0, 1) ? CSR_M_TVEC : CSR_S_TVEC,
                                     VAR_RW, 5'd1, $urandom));
                send_event(csr_event(CSR_M_STATUS, $urandom_range(0, 1) ? VAR_RS : VAR_RC,
                                     5'd1, $urandom & 32'h0000_000A));
                if ($urandom_range(0, 1))
                    send_event(csr_event(CSR_M_IP, VAR_RW, 5'd1, $urandom & 32'h0000_0AAA));
                it = fill_event(OP_CMP_LO);
                send_event(it);
                it = fill_event(OP_CMP_HI);
                if ($urandom_range(0, 1)) it.operand_value = $urandom_range(0, 2);
                send_event(it);
                send_event(fill_event(OP_EXT));
                repeat ($urandom_range(1, 3)) send_event(fill_event(OP_IRQ));
            end else begin
                // wfi with a guaranteed wake-up on the machine external interrupt
                send_event(csr_event(CSR_M_IE, VAR_RS, 5'd1,
                                     (32'd1 << IP_MEIP) | ($urandom & 32'h0000_0AAA)));
                send_event(csr_event(CSR_M_IDELEG, VAR_RC, 5'd1, 32'd1 << IP_MEIP));
                send_event(fill_event(OP_WFI));
                n = $urandom_range(0, 3);
                repeat (n) send_event(fill_event(4'(OP_CSR + $urandom_range(0, 6))));
                it = fill_event(OP_EXT);
                it.ext_levels[0] = 1'b1;
                send_event(it);
                send_event(fill_event(OP_IRQ));
            end
        end
        in_valid <= 1'b0;

        // drain: all results in, then a wait for anything stray
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (6) @(posedge clk);
        if (fail_count == 0) $display("[privileged_trap_csr_unit] OK");
        else $display("[privileged_trap_csr_unit] ERROR");
        $finish;
    end

endmodule
